@@ rtl/rwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_KERNEL = 5;
	localparam int COEFF_BITS = 12;
	localparam int FRAC_BITS  = 8;

	localparam int STORE_ROWS = MAX_KERNEL + 1;
	localparam int WIN        = 5;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int BANK_W     = $clog2(STORE_ROWS);
	localparam int SLOT_W     = 3;
	localparam int PIX_W      = 24;
	localparam int CH_W       = 8;
	localparam int NCH        = 3;
	localparam int CFG_W      = 60;
	localparam int REG_IDX_W  = 3;
	localparam int WREG_W     = 12;
	localparam int HREG_W     = 16;
	localparam int PROD_W     = COEFF_BITS + CH_W + 1;
	localparam int ROW_SUM_W  = PROD_W + 3;
	localparam int SUM_W      = ROW_SUM_W + 3;

	// row offset of the top window row, taken modulo the bank count
	localparam int ROW_BACK   = STORE_ROWS - (WIN / 2);

	localparam logic [REG_IDX_W-1:0] REG_COEFF_ROW0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_ROW1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_ROW2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_ROW3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_ROW4 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 3'd7;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [STORE_ROWS-1:0][PIX_W-1:0] bank_data_t;

	typedef struct packed {
		logic            kind;
		logic [CH_W-1:0] chan0;
		logic [CH_W-1:0] chan1;
		logic [CH_W-1:0] chan2;
	} px_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_chan0;
		logic [CH_W-1:0] out_chan1;
		logic [CH_W-1:0] out_chan2;
		logic            last;
	} px_out_t;

	typedef struct packed {
		logic              we;
		logic [BANK_W-1:0] wbank;
		logic [COL_W-1:0]  waddr;
		pix_t              wdata;
		logic              re;
		logic [COL_W-1:0]  addr_a;
		logic [COL_W-1:0]  addr_b;
	} ls_req_t;

	// (x + n) mod 5, x below 5, n below 8
	function automatic logic [SLOT_W-1:0] mod5_add(input logic [SLOT_W-1:0] x,
		input logic [SLOT_W-1:0] n);
		logic [SLOT_W:0] s;
		s = {1'b0, x} + {1'b0, n};
		if (s >= 4'd10) begin
			s = s - 4'd10;
		end else if (s >= 4'd5) begin
			s = s - 4'd5;
		end
		return s[SLOT_W-1:0];
	endfunction

	// bank holding window row k for center row whose bank is row6
	function automatic logic [BANK_W-1:0] bank_of(input logic [BANK_W-1:0] row6,
		input logic [SLOT_W-1:0] k);
		logic [BANK_W+1:0] s;
		s = (BANK_W+2)'(row6) + (BANK_W+2)'(ROW_BACK) + (BANK_W+2)'(k);
		if (s >= (BANK_W+2)'(2 * STORE_ROWS)) begin
			s = s - (BANK_W+2)'(2 * STORE_ROWS);
		end else if (s >= (BANK_W+2)'(STORE_ROWS)) begin
			s = s - (BANK_W+2)'(STORE_ROWS);
		end
		return s[BANK_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/rwc_line_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwc_line_store (
	input  wire logic               clk,
	input  wire rwc_pkg::ls_req_t   req,
	output rwc_pkg::bank_data_t     rd_a,
	output rwc_pkg::bank_data_t     rd_b
);
	import rwc_pkg::*;

	pix_t wdata_q;

	always_ff @(posedge clk) begin
		if (req.re) begin
			wdata_q <= req.wdata;
		end
	end

	// one bank per stored row: one write port, two read ports
	for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
		logic [PIX_W-1:0] mem [MAX_WIDTH];
		pix_t rda_q;
		pix_t rdb_q;
		logic fwa_q;
		logic fwb_q;
		logic hit;

		assign hit = req.we && (req.wbank == BANK_W'(b));

		always_ff @(posedge clk) begin
			if (hit) begin
				mem[req.waddr] <= req.wdata;
			end
			if (req.re) begin
				rda_q <= mem[req.addr_a];
				rdb_q <= mem[req.addr_b];
				fwa_q <= hit && (req.waddr == req.addr_a);
				fwb_q <= hit && (req.waddr == req.addr_b);
			end
		end

		// same-cycle write to the read address: pass new data through
		assign rd_a[b] = fwa_q ? wdata_q : rda_q;
		assign rd_b[b] = fwb_q ? wdata_q : rdb_q;
	end

endmodule

`default_nettype wire

@@ rtl/rgb_window_convolution.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// in        in_valid / in_ready   in_data  (kind, chan0..chan2)
// out       out_valid / out_ready out_data (out_chan0..out_chan2, last)
// cfg       cfg_we                cfg_index, cfg_data (write only)
//
// One item per cycle sustained while out_ready holds. Each result is registered
// stage by stage from the edge that accepts the item that releases it; the line
// store read registers at that edge, then the products, the row sums and the clamp.
// Reset clears positions, configuration and valid bits, not data or the line store.
// Each stage holds while the one after it is full, so in_ready falls only
// when every stage up to the output register holds an item.

module rgb_window_convolution (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire rwc_pkg::px_in_t                in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output rwc_pkg::px_out_t                    out_data,
	input  wire logic                           cfg_we,
	input  wire logic [rwc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [rwc_pkg::CFG_W-1:0]      cfg_data
);
	import rwc_pkg::*;

	localparam int DIFF_W = COL_W + 2;
	localparam logic [9:0] GREY_MUL = 10'd683;   // 683/2048 ~ 1/3, exact below 768
	localparam int GREY_SHIFT = 11;

	typedef struct packed {
		logic              pass;
		logic              last;
		logic [SLOT_W-1:0] cm5;
		logic [BANK_W-1:0] row6;
		logic [SLOT_W-1:0] slot_a;
		logic [SLOT_W-1:0] slot_b;
		logic              use_b;
	} s1_ctl_t;

	// ---------------- configuration ----------------
	logic [CFG_W-1:0]  coeff_q [WIN];
	logic [1:0]        mode_q;
	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q[0] <= '0;
			coeff_q[1] <= CFG_W'(64'h100000);
			coeff_q[2] <= '0;
			coeff_q[3] <= '0;
			coeff_q[4] <= '0;
			mode_q     <= '0;
			width_q    <= WREG_W'(640);
			height_q   <= HREG_W'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEFF_ROW0: coeff_q[0] <= cfg_data;
				REG_COEFF_ROW1: coeff_q[1] <= cfg_data;
				REG_COEFF_ROW2: coeff_q[2] <= cfg_data;
				REG_COEFF_ROW3: coeff_q[3] <= cfg_data;
				REG_COEFF_ROW4: coeff_q[4] <= cfg_data;
				REG_MODE:       mode_q     <= cfg_data[1:0];
				REG_WIDTH:      width_q    <= cfg_data[WREG_W-1:0];
				REG_HEIGHT:     height_q   <= cfg_data[HREG_W-1:0];
				default: ;
			endcase
		end
	end

	logic              r2;
	logic [1:0]        rad;
	logic [WREG_W-1:0] w_eff;
	logic [HREG_W-1:0] h_eff;

	assign r2    = mode_q[0] && (MAX_KERNEL >= 5);
	assign rad   = r2 ? 2'd2 : 2'd1;
	assign w_eff = (width_q == '0) ? WREG_W'(1) :
		(width_q > WREG_W'(MAX_WIDTH)) ? WREG_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q == '0) ? HREG_W'(1) : height_q;

	// ---------------- stage handshake ----------------
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en1, en2, en3, en_o, accept;

	assign en_o     = !out_valid_q || out_ready;
	assign en3      = !v_s3 || en_o;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && in_ready;

	// ---------------- positions ----------------
	logic [HREG_W-1:0] in_row_q, out_row_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [BANK_W-1:0] in_row6_q, out_row6_q;
	logic [SLOT_W-1:0] out_cm5_q;
	logic [DIFF_W-1:0] diff_q;   // pixels stored but not yet sent

	logic [HREG_W-1:0] ir, orw, ir_n, or_n;
	logic [COL_W-1:0]  ic, oc, ic_n, oc_n;
	logic [BANK_W-1:0] ir6, or6, ir6_n, or6_n;
	logic [SLOT_W-1:0] cm5, cm5_n;
	logic [DIFF_W-1:0] diff, diff_w, diff_n, delay;
	logic [COL_W:0]    ic_inc, oc_inc, oc_far;
	logic [HREG_W:0]   or_far;
	logic              restart, wr, in_wrap, out_wrap, emit, pass0, last0;
	logic [9:0]        grey_sum;
	logic [19:0]       grey_prod;
	logic [CH_W-1:0]   grey;
	pix_t              wpix;
	ls_req_t           ls_req;
	s1_ctl_t           ctl0;

	always_comb begin
		restart = out_row_q >= h_eff;
		ir   = restart ? '0 : in_row_q;
		ic   = restart ? '0 : in_col_q;
		ir6  = restart ? '0 : in_row6_q;
		orw  = restart ? '0 : out_row_q;
		oc   = restart ? '0 : out_col_q;
		or6  = restart ? '0 : out_row6_q;
		cm5  = restart ? '0 : out_cm5_q;
		diff = restart ? '0 : diff_q;

		grey_sum  = 10'(in_data.chan0) + 10'(in_data.chan1) + 10'(in_data.chan2);
		grey_prod = 20'(grey_sum) * 20'(GREY_MUL);
		grey      = grey_prod[GREY_SHIFT +: CH_W];
		wpix      = mode_q[1] ? {grey, grey, grey}
			: {in_data.chan2, in_data.chan1, in_data.chan0};

		// surplus pixels after a complete frame act as flush items
		wr      = accept && !in_data.kind && (ir < h_eff);
		ic_inc  = {1'b0, ic} + (COL_W+1)'(1);
		in_wrap = ic_inc >= w_eff;
		ic_n    = ic;
		ir_n    = ir;
		ir6_n   = ir6;
		if (wr) begin
			ic_n = in_wrap ? '0 : ic_inc[COL_W-1:0];
			if (in_wrap) begin
				ir_n  = ir + 1'b1;
				ir6_n = (ir6 == BANK_W'(STORE_ROWS - 1)) ? '0 : ir6 + 1'b1;
			end
		end
		diff_w = diff + DIFF_W'(wr);
		delay  = r2 ? (DIFF_W'({w_eff, 1'b0}) + DIFF_W'(2)) : (DIFF_W'(w_eff) + DIFF_W'(1));
		emit   = accept && ((ir_n >= h_eff) || (diff_w > delay));

		oc_far = {1'b0, oc} + (COL_W+1)'(rad);
		or_far = {1'b0, orw} + (HREG_W+1)'(rad);
		pass0  = (orw < HREG_W'(rad)) || (oc < COL_W'(rad)) ||
			(or_far >= (HREG_W+1)'(h_eff)) || (oc_far >= (COL_W+1)'(w_eff));
		last0  = (orw == h_eff - 1'b1) && ((COL_W+1)'(oc) == w_eff - 1'b1);

		oc_inc   = {1'b0, oc} + (COL_W+1)'(1);
		out_wrap = oc_inc >= w_eff;
		oc_n   = oc;
		or_n   = orw;
		or6_n  = or6;
		cm5_n  = cm5;
		diff_n = diff_w;
		if (emit) begin
			diff_n = diff_w - 1'b1;
			if (out_wrap) begin
				oc_n  = '0;
				cm5_n = '0;
				or_n  = orw + 1'b1;
				or6_n = (or6 == BANK_W'(STORE_ROWS - 1)) ? '0 : or6 + 1'b1;
			end else begin
				oc_n  = oc_inc[COL_W-1:0];
				cm5_n = mod5_add(cm5, SLOT_W'(1));
			end
			if (last0) begin
				ir_n = '0; ic_n = '0; ir6_n = '0; or_n = '0; oc_n = '0;
				or6_n = '0; cm5_n = '0; diff_n = '0;
			end
		end

		ctl0.pass   = pass0;
		ctl0.last   = last0;
		ctl0.cm5    = cm5;
		ctl0.row6   = or6;
		ctl0.slot_a = mod5_add(cm5, SLOT_W'(rad));
		ctl0.slot_b = cm5;
		ctl0.use_b  = oc < COL_W'(rad);

		// column c+R for the window, column c for the left margin
		ls_req.we     = wr;
		ls_req.wbank  = ir6;
		ls_req.waddr  = ic;
		ls_req.wdata  = wpix;
		ls_req.re     = en1;
		ls_req.addr_a = oc_far[COL_W-1:0];
		ls_req.addr_b = oc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_row6_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_row6_q <= '0;
			out_cm5_q  <= '0;
			diff_q     <= '0;
		end else if (accept) begin
			in_row_q   <= ir_n;
			in_col_q   <= ic_n;
			in_row6_q  <= ir6_n;
			out_row_q  <= or_n;
			out_col_q  <= oc_n;
			out_row6_q <= or6_n;
			out_cm5_q  <= cm5_n;
			diff_q     <= diff_n;
		end
	end

	// ---------------- line store ----------------
	bank_data_t rd_a, rd_b;

	rwc_line_store u_store (
		.clk  (clk),
		.req  (ls_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	// ---------------- stage 1: window assembly and products ----------------
	s1_ctl_t ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && emit) begin
			ctl_s1 <= ctl0;
		end
	end

	// window columns, slot = column mod 5, rows ordered top to bottom
	pix_t slot_q [WIN][WIN];
	pix_t eff    [WIN][WIN];
	pix_t win    [WIN][WIN];
	pix_t col_a  [WIN];
	pix_t col_b  [WIN];
	logic signed [COEFF_BITS-1:0] kern [WIN][WIN];
	logic use_win [WIN][WIN];
	logic signed [PROD_W-1:0] prod_d [NCH][WIN][WIN];

	for (genvar k = 0; k < WIN; k++) begin : g_kr
		for (genvar m = 0; m < WIN; m++) begin : g_kc
			if (k >= 1 && k <= WIN - 2 && m >= 1 && m <= WIN - 2) begin : g_in
				assign kern[k][m] = r2 ? coeff_q[k][COEFF_BITS*m +: COEFF_BITS]
					: coeff_q[k-1][COEFF_BITS*(m-1) +: COEFF_BITS];
				assign use_win[k][m] = 1'b1;
			end else begin : g_out
				assign kern[k][m] = r2 ? coeff_q[k][COEFF_BITS*m +: COEFF_BITS] : '0;
				assign use_win[k][m] = r2;
			end
		end
	end

	always_comb begin
		logic [CH_W-1:0] opx;
		for (int k = 0; k < WIN; k++) begin
			col_a[k] = rd_a[bank_of(ctl_s1.row6, SLOT_W'(k))];
			col_b[k] = rd_b[bank_of(ctl_s1.row6, SLOT_W'(k))];
		end
		for (int j = 0; j < WIN; j++) begin
			for (int k = 0; k < WIN; k++) begin
				if (ctl_s1.slot_a == SLOT_W'(j)) begin
					eff[j][k] = col_a[k];
				end else if (ctl_s1.use_b && ctl_s1.slot_b == SLOT_W'(j)) begin
					eff[j][k] = col_b[k];
				end else begin
					eff[j][k] = slot_q[j][k];
				end
			end
		end
		// column offset m-2 sits in slot (cm5 + m + 3) mod 5
		for (int m = 0; m < WIN; m++) begin
			for (int k = 0; k < WIN; k++) begin
				win[k][m] = eff[mod5_add(ctl_s1.cm5, SLOT_W'(m + 3))][k];
			end
		end
		for (int c = 0; c < NCH; c++) begin
			for (int k = 0; k < WIN; k++) begin
				for (int m = 0; m < WIN; m++) begin
					opx = use_win[k][m] ? win[k][m][CH_W*c +: CH_W] : '0;
					prod_d[c][k][m] = PROD_W'(kern[k][m] * $signed({1'b0, opx}));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			for (int j = 0; j < WIN; j++) begin
				for (int k = 0; k < WIN; k++) begin
					slot_q[j][k] <= eff[j][k];
				end
			end
		end
	end

	// ---------------- stage 2: products ----------------
	logic signed [PROD_W-1:0] prod_s2 [NCH][WIN][WIN];
	pix_t center_s2;
	logic pass_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			prod_s2   <= prod_d;
			center_s2 <= win[WIN/2][WIN/2];
			pass_s2   <= ctl_s1.pass;
			last_s2   <= ctl_s1.last;
		end
	end

	// ---------------- stage 3: row sums ----------------
	logic signed [ROW_SUM_W-1:0] rsum_d  [NCH][WIN];
	logic signed [ROW_SUM_W-1:0] rsum_s3 [NCH][WIN];
	pix_t center_s3;
	logic pass_s3, last_s3;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			for (int k = 0; k < WIN; k++) begin
				rsum_d[c][k] = '0;
				for (int m = 0; m < WIN; m++) begin
					rsum_d[c][k] = rsum_d[c][k] + ROW_SUM_W'(prod_s2[c][k][m]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			rsum_s3   <= rsum_d;
			center_s3 <= center_s2;
			pass_s3   <= pass_s2;
			last_s3   <= last_s2;
		end
	end

	// ---------------- output: total, truncate, saturate, or pass the center ----------------
	logic signed [SUM_W-1:0] tot;
	logic signed [SUM_W-1:0] q;
	logic [CH_W-1:0] chv [NCH];
	px_out_t out_d, out_q;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			tot = '0;
			for (int k = 0; k < WIN; k++) begin
				tot = tot + SUM_W'(rsum_s3[c][k]);
			end
			q = tot >>> FRAC_BITS;
			if (tot <= 0) begin
				chv[c] = '0;
			end else if (q > SUM_W'(255)) begin
				chv[c] = 8'hFF;
			end else begin
				chv[c] = q[CH_W-1:0];
			end
			if (pass_s3) begin
				chv[c] = center_s3[CH_W*c +: CH_W];
			end
		end
		out_d.out_chan0 = chv[0];
		out_d.out_chan1 = chv[1];
		out_d.out_chan2 = chv[2];
		out_d.last      = last_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s3) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_ready_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid_q && v_s1 && v_s2 && v_s3))
		else $error("input stalled with a free stage");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last0) |=> (in_row_q == '0 && out_row_q == '0 && diff_q == '0))
		else $error("positions not cleared after frame end");

	a_slots_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ctl_s1.use_b) |-> (ctl_s1.slot_a != ctl_s1.slot_b))
		else $error("two column loads hit one slot");

	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s3))
		else $error("result without a stage-3 item");
`endif

endmodule

`default_nettype wire
